@@ rtl/core/swm_pkg.sv @@
package swm_pkg;

	localparam int CMD_BITS = 2;
	localparam int SEQ_BITS = 32;
	localparam int CFG_BITS = 7;

	localparam logic [CMD_BITS-1:0] CMD_COMMIT = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_PEEK   = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic scan_start;
		logic scan_finish;
	} swm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_scan;
		logic scan_done;
	} swm_sts_t;

endpackage

@@ rtl/core/swm_if.sv @@
interface swm_in_if import swm_pkg::*; #(
	parameter int SAMPLE_BITS = 32
);
	logic                          valid;
	logic                          ready;
	logic [CMD_BITS-1:0]           cmd;
	logic [SEQ_BITS-1:0]           seq_number;
	logic signed [SAMPLE_BITS-1:0] sample_value;

	modport source (output valid, cmd, seq_number, sample_value, input ready);
	modport sink (input valid, cmd, seq_number, sample_value, output ready);
endinterface

interface swm_out_if #(
	parameter int SAMPLE_BITS = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] window_min;
	logic                          seq_error;

	modport source (output valid, window_min, seq_error, input ready);
	modport sink (input valid, window_min, seq_error, output ready);
endinterface

interface swm_cfg_if import swm_pkg::*;;
	logic                valid;
	logic                ready;
	logic [CFG_BITS-1:0] window_length;

	modport source (output valid, window_length, input ready);
	modport sink (input valid, window_length, output ready);
endinterface

@@ rtl/core/swm_outq.sv @@
module swm_outq #(
	parameter int SAMPLE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic signed [SAMPLE_BITS-1:0] push_min,
	input  logic                          push_err,
	output logic                          full,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] out_min,
	output logic                          out_err
);
	logic [1:0]                    count_q;
	logic signed [SAMPLE_BITS-1:0] min0_q, min1_q;
	logic                          err0_q, err1_q;
	logic                          pop;
	logic                          head_wr;

	assign out_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign pop       = out_valid && out_ready;
	assign out_min   = min0_q;
	assign out_err   = err0_q;
	assign head_wr   = push && ((count_q == 2'd0) || (pop && count_q == 2'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// head always sits in entry 0
	always_ff @(posedge clk) begin
		if (head_wr) begin
			min0_q <= push_min;
			err0_q <= push_err;
		end else if (pop) begin
			min0_q <= min1_q;
			err0_q <= err1_q;
		end
		if (push && !head_wr) begin
			min1_q <= push_min;
			err1_q <= push_err;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("result queue overflow");

endmodule

@@ rtl/core/swm_ctrl.sv @@
module swm_ctrl import swm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     q_full,
	input  swm_sts_t sts,
	output swm_cmd_t cmd
);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;

	assign in_ready        = (state_q == ST_IDLE) && !q_full;
	assign cmd.accept      = in_valid && in_ready;
	assign cmd.scan_start  = cmd.accept && sts.need_scan;
	assign cmd.scan_finish = (state_q == ST_SCAN) && sts.scan_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (cmd.scan_start) state_q <= ST_SCAN;
				ST_SCAN: if (cmd.scan_finish) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_start_enters_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_start |=> state_q == ST_SCAN)
		else $error("rescan start did not enter scan state");

	a_done_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		sts.scan_done |-> state_q == ST_SCAN)
		else $error("rescan done outside scan state");

endmodule

@@ rtl/core/swm_dp.sv @@
module swm_dp import swm_pkg::*; #(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [CFG_BITS-1:0]           cfg_window_length,
	input  logic [CMD_BITS-1:0]           in_cmd,
	input  logic [SEQ_BITS-1:0]           in_seq_number,
	input  logic signed [SAMPLE_BITS-1:0] in_sample_value,
	input  swm_cmd_t                      cmd,
	output swm_sts_t                      sts,
	output logic                          push,
	output logic signed [SAMPLE_BITS-1:0] push_min,
	output logic                          push_err
);
	localparam int AW = $clog2(MAX_WINDOW);
	localparam int LW = AW + 1;

	logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];

	logic [LW-1:0]                 win_len_q;
	logic [AW-1:0]                 min_slot_q, write_slot_q;
	logic [SEQ_BITS-1:0]           next_seq_q;
	logic                          filled_q;
	logic signed [SAMPLE_BITS-1:0] min_val_q;

	// rescan
	logic [AW-1:0]                 scan_idx_q, best_slot_q, raddr_q, rd_addr_s1;
	logic                          scan_commit_q, issue_q, rd_valid_s1, rd_last_s1;
	logic                          scan_done_q;
	logic signed [SAMPLE_BITS-1:0] best_val_q, rd_data_s1;

	logic cmd_ok, seq_ok, valid_op, is_commit, v_le_min, take_v, mem_we;
	logic raddr_last;
	logic signed [SAMPLE_BITS-1:0] res_val;
	logic [LW-1:0] len_sat, ws_plus2;

	assign cmd_ok    = (in_cmd == CMD_COMMIT) || (in_cmd == CMD_PEEK);
	assign seq_ok    = (in_seq_number == next_seq_q);
	assign valid_op  = cmd_ok && seq_ok;
	assign is_commit = (in_cmd == CMD_COMMIT);
	assign v_le_min  = (in_sample_value <= min_val_q);
	// first sample after a clear is its own minimum
	assign take_v    = (!filled_q && write_slot_q == '0) || v_le_min;
	assign res_val   = take_v ? in_sample_value : min_val_q;
	assign mem_we    = cmd.accept && valid_op && is_commit;
	assign ws_plus2  = {1'b0, write_slot_q} + LW'(2);
	assign raddr_last = ({1'b0, raddr_q} == win_len_q - LW'(1));

	assign sts.need_scan = valid_op && filled_q && !v_le_min && (write_slot_q == min_slot_q);
	assign sts.scan_done = scan_done_q;

	assign push = (cmd.accept && !sts.need_scan) || cmd.scan_finish;
	always_comb begin
		push_min = '0;
		push_err = 1'b0;
		priority if (cmd.scan_finish) begin
			push_min = best_val_q;
		end else if (!cmd_ok) begin
			push_min = '0;
		end else if (!seq_ok) begin
			push_err = 1'b1;
		end else begin
			push_min = res_val;
		end
	end

	always_comb begin
		if (int'(cfg_window_length) < 2) begin
			len_sat = LW'(2);
		end else if (int'(cfg_window_length) > MAX_WINDOW) begin
			len_sat = LW'(MAX_WINDOW);
		end else begin
			len_sat = LW'(cfg_window_length);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q    <= (14 > MAX_WINDOW) ? LW'(MAX_WINDOW) : LW'(14);
			min_slot_q   <= '0;
			write_slot_q <= '0;
			next_seq_q   <= '0;
			filled_q     <= 1'b0;
		end else if (cfg_valid) begin
			win_len_q    <= len_sat;
			min_slot_q   <= '0;
			write_slot_q <= '0;
			next_seq_q   <= '0;
			filled_q     <= 1'b0;
		end else if (cmd.accept && in_cmd == CMD_CLEAR) begin
			min_slot_q   <= '0;
			write_slot_q <= '0;
			next_seq_q   <= '0;
			filled_q     <= 1'b0;
		end else if (mem_we) begin
			next_seq_q <= next_seq_q + SEQ_BITS'(1);
			if (take_v) min_slot_q <= write_slot_q;
			if (filled_q) begin
				if ({1'b0, write_slot_q} == win_len_q - LW'(1)) write_slot_q <= '0;
				else write_slot_q <= write_slot_q + AW'(1);
			end else begin
				write_slot_q <= write_slot_q + AW'(1);
				if (ws_plus2 >= win_len_q) filled_q <= 1'b1;
			end
		end else if (cmd.scan_finish && scan_commit_q) begin
			min_slot_q <= best_slot_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we && take_v) begin
			min_val_q <= in_sample_value;
		end else if (cmd.scan_finish && scan_commit_q) begin
			min_val_q <= best_val_q;
		end
	end

	// sample ring, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) ring[write_slot_q] <= in_sample_value;
		rd_data_s1 <= ring[raddr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q     <= 1'b0;
			rd_valid_s1 <= 1'b0;
			scan_done_q <= 1'b0;
			raddr_q     <= '0;
		end else begin
			rd_valid_s1 <= issue_q;
			scan_done_q <= rd_valid_s1 && rd_last_s1;
			if (cmd.scan_start) begin
				issue_q <= 1'b1;
				raddr_q <= '0;
			end else if (issue_q) begin
				raddr_q <= raddr_q + AW'(1);
				if (raddr_last) issue_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= raddr_q;
		rd_last_s1 <= raddr_last;
		if (cmd.scan_start) begin
			scan_idx_q    <= write_slot_q;
			scan_commit_q <= is_commit;
			best_val_q    <= in_sample_value;
			best_slot_q   <= write_slot_q;
		end else if (rd_valid_s1 && rd_addr_s1 != scan_idx_q && rd_data_s1 < best_val_q) begin
			// strict compare keeps the new sample, then the lowest slot, on ties
			best_val_q  <= rd_data_s1;
			best_slot_q <= rd_addr_s1;
		end
	end

	a_scan_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> ({1'b0, rd_addr_s1} < win_len_q))
		else $error("rescan read outside the window");

	a_no_write_during_scan: assert property (@(posedge clk) disable iff (!arst_n)
		issue_q |-> !mem_we)
		else $error("ring written while rescan is running");

endmodule

@@ rtl/core/sliding_window_minimum_top.sv @@
// Sliding window minimum over the last window_length signed Q16.16 samples.
// Each sample_ch transaction (commit, peek, clear or an unused command) yields
// exactly one result_ch transaction, in order, through a two-entry result
// queue. The result is registered in that queue on acceptance, or at the end
// of the rescan when one is needed. When a commit or peek overwrites the slot
// holding the current minimum with a larger sample, the block rescans the ring
// through its single read port; sample_ch.ready is low during that rescan. A
// cfg_ch write saturates the length into 2..MAX_WINDOW and clears the window;
// write it only while the block is idle.
module sliding_window_minimum_top import swm_pkg::*; #(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 32
) (
	input logic         clk,
	input logic         arst_n,
	swm_in_if.sink      sample_ch,
	swm_out_if.source   result_ch,
	swm_cfg_if.sink     cfg_ch
);
	swm_cmd_t                      cmd;
	swm_sts_t                      sts;
	logic                          q_full, push, push_err;
	logic signed [SAMPLE_BITS-1:0] push_min;

	assign cfg_ch.ready = 1'b1;

	swm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_ch.valid),
		.in_ready (sample_ch.ready),
		.q_full   (q_full),
		.sts      (sts),
		.cmd      (cmd)
	);

	swm_dp #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_ch.valid),
		.cfg_window_length (cfg_ch.window_length),
		.in_cmd            (sample_ch.cmd),
		.in_seq_number     (sample_ch.seq_number),
		.in_sample_value   (sample_ch.sample_value),
		.cmd               (cmd),
		.sts               (sts),
		.push              (push),
		.push_min          (push_min),
		.push_err          (push_err)
	);

	swm_outq #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_min  (push_min),
		.push_err  (push_err),
		.full      (q_full),
		.out_valid (result_ch.valid),
		.out_ready (result_ch.ready),
		.out_min   (result_ch.window_min),
		.out_err   (result_ch.seq_error)
	);

endmodule

@@ tb/sv/window_min_monitor.sv @@
`timescale 1ns / 100ps

module window_min_monitor import swm_pkg::*; #(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	swm_in_if   sample_ch,
	swm_out_if  result_ch,
	swm_cfg_if  cfg_ch,
	output int  mins_outstanding,
	output int  mismatch_count
);

	localparam int MIN_WINDOW   = 2;
	localparam int RESET_WINDOW = 14;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		sample_t window_min;
		logic    seq_error;
	} min_result_t;

	sample_t             ring [MAX_WINDOW];
	int                  min_slot;
	int                  write_slot;
	logic [SEQ_BITS-1:0] seq_due;
	logic                filled;
	int                  win_len;
	min_result_t         expected_mins [$];
	int                  fail_count = 0;

	assign mismatch_count = fail_count;

	task automatic report_mismatch(input string what);
		$display("[%0t] window min mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	function automatic void clear_window();
		min_slot   = 0;
		write_slot = 0;
		seq_due    = '0;
		filled     = 1'b0;
	endfunction

	// minimum once v sits in slot idx of a full window
	function automatic sample_t steady_min(input int idx, input sample_t v, output int slot);
		sample_t prev;
		sample_t best;
		prev = ring[min_slot];
		if (v <= prev) begin
			slot = idx;
			return v;
		end
		if (idx != min_slot) begin
			slot = min_slot;
			return prev;
		end
		// old minimum is evicted: rescan the rest of the window
		best = v;
		slot = idx;
		for (int i = 0; i < win_len; i++) begin
			if (i != idx && ring[i] < best) begin
				best = ring[i];
				slot = i;
			end
		end
		return best;
	endfunction

	function automatic min_result_t predict_window_min(input logic [CMD_BITS-1:0] cmd,
			input logic [SEQ_BITS-1:0] seq, input sample_t v);
		min_result_t res;
		int          slot;
		res = '0;
		if (cmd == CMD_CLEAR) begin
			clear_window();
			return res;
		end
		if (cmd != CMD_COMMIT && cmd != CMD_PEEK) begin
			return res;
		end
		if (seq != seq_due) begin
			res.seq_error = 1'b1;
			return res;
		end
		if (cmd == CMD_PEEK) begin
			if (filled) begin
				res.window_min = steady_min(write_slot, v, slot);
			end else if (write_slot == 0) begin
				res.window_min = v;
			end else begin
				res.window_min = (v <= ring[min_slot]) ? v : ring[min_slot];
			end
		end else if (filled) begin
			res.window_min = steady_min(write_slot, v, slot);
			min_slot = slot;
			ring[write_slot] = v;
			write_slot = (write_slot + 1 >= win_len) ? 0 : write_slot + 1;
			seq_due++;
		end else begin
			// warm-up: a tie moves the minimum to the new slot
			ring[write_slot] = v;
			if (v <= ring[min_slot]) begin
				min_slot = write_slot;
				res.window_min = v;
			end else begin
				res.window_min = ring[min_slot];
			end
			write_slot++;
			if (write_slot + 1 >= win_len) begin
				filled = 1'b1;
			end
			seq_due++;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		min_result_t want;
		if (!arst_n) begin
			foreach (ring[i]) ring[i] = '0;
			win_len = RESET_WINDOW;
			clear_window();
			expected_mins.delete();
			mins_outstanding <= 0;
		end else begin
			// a result never leaves in the cycle of its acceptance, so pop before push
			if (result_ch.valid && result_ch.ready) begin
				if (expected_mins.size() == 0) begin
					report_mismatch("result transaction with nothing expected");
				end else begin
					want = expected_mins.pop_front();
					if (result_ch.window_min !== want.window_min) begin
						report_mismatch($sformatf("window_min %0d, expected %0d",
							result_ch.window_min, want.window_min));
					end
					if (result_ch.seq_error !== want.seq_error) begin
						report_mismatch($sformatf("seq_error %b, expected %b",
							result_ch.seq_error, want.seq_error));
					end
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				if (cfg_ch.window_length < MIN_WINDOW) begin
					win_len = MIN_WINDOW;
				end else if (cfg_ch.window_length > MAX_WINDOW) begin
					win_len = MAX_WINDOW;
				end else begin
					win_len = cfg_ch.window_length;
				end
				clear_window();
			end
			if (sample_ch.valid && sample_ch.ready) begin
				expected_mins.push_back(predict_window_min(sample_ch.cmd,
					sample_ch.seq_number, sample_ch.sample_value));
			end
			mins_outstanding <= expected_mins.size();
		end
	end

endmodule

@@ tb/sv/sliding_window_minimum_top_tb.sv @@
`timescale 1ns / 100ps

module sliding_window_minimum_top_tb;
	import swm_pkg::*;

	localparam int MAX_WINDOW    = 64;
	localparam int SAMPLE_BITS   = 32;
	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = MAX_WINDOW + 16;
	localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef enum int {
		VAL_WIDE,
		VAL_NARROW,
		VAL_RISING,
		VAL_EXTREME,
		VAL_MIXED
	} value_style_t;

	logic                clk;
	logic                arst_n;
	int                  send_idle_pct;
	int                  recv_stall_pct = 0;
	int                  idle_cycles = 0;
	int                  mins_outstanding;
	int                  mismatch_count;
	logic [SEQ_BITS-1:0] seq_next;
	sample_t             ramp_level;

	swm_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
	swm_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_ch ();
	swm_cfg_if                              cfg_ch ();

	sliding_window_minimum_top #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample_ch(sample_ch),
		.result_ch(result_ch),
		.cfg_ch   (cfg_ch)
	);

	window_min_monitor #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_min_monitor (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_ch       (sample_ch),
		.result_ch       (result_ch),
		.cfg_ch          (cfg_ch),
		.mins_outstanding(mins_outstanding),
		.mismatch_count  (mismatch_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// stop a hung run: too many cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic send_item(input logic [CMD_BITS-1:0] cmd, input logic [SEQ_BITS-1:0] seq,
			input sample_t value);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid        <= 1'b1;
		sample_ch.cmd          <= cmd;
		sample_ch.seq_number   <= seq;
		sample_ch.sample_value <= value;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		if (cmd == CMD_CLEAR) begin
			seq_next = '0;
		end else if (cmd == CMD_COMMIT && seq == seq_next) begin
			seq_next = seq_next + 1'b1;
		end
	endtask

	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		do @(posedge clk); while (mins_outstanding != 0);
	endtask

	task automatic write_length(input logic [CFG_BITS-1:0] len);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_ch.valid         <= 1'b1;
		cfg_ch.window_length <= len;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		seq_next = '0;
	endtask

	function automatic sample_t pick_sample(input value_style_t style);
		value_style_t s;
		s = (style == VAL_MIXED) ? value_style_t'($urandom_range(VAL_EXTREME)) : style;
		case (s)
		VAL_WIDE: return $urandom;
		VAL_NARROW: return sample_t'($urandom_range(8)) - 4;
		VAL_RISING: begin
			// rising values keep evicting the oldest minimum
			ramp_level = ramp_level + sample_t'($urandom_range(3));
			return ramp_level;
		end
		default: begin
			case ($urandom_range(3))
			0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			2: return '0;
			default: return '1;
			endcase
		end
		endcase
	endfunction

	task automatic run_segment(input logic [CFG_BITS-1:0] len, input int count);
		value_style_t        style;
		logic [CMD_BITS-1:0] cmd;
		logic [SEQ_BITS-1:0] seq;
		int                  pick;
		int                  phase;
		phase = $urandom_range(3);
		style = VAL_MIXED;
		write_length(len);
		for (int k = 0; k < count; k++) begin
			if (k % 32 == 0) begin
				phase = (phase + 1) % 4;
				case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
				1: begin send_idle_pct = 47; recv_stall_pct <= 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct <= 47; end
				default: begin send_idle_pct = 30; recv_stall_pct <= 30; end
				endcase
				style      = value_style_t'($urandom_range(VAL_MIXED));
				ramp_level = $urandom;
			end
			if ($urandom_range(99) == 0) begin
				wait_drained();
			end
			// clears stay rare so that long windows still fill up
			pick = $urandom_range(199);
			if (pick < 160) begin
				cmd = CMD_COMMIT;
			end else if (pick < 195) begin
				cmd = CMD_PEEK;
			end else if (pick < 197) begin
				cmd = CMD_CLEAR;
			end else begin
				cmd = CMD_UNUSED;
			end
			seq = seq_next;
			if ($urandom_range(99) < 4) begin
				seq = $urandom_range(1) ? $urandom : seq_next + $urandom_range(3, 1);
			end
			send_item(cmd, seq, pick_sample(style));
		end
	endtask

	initial begin
		arst_n                 <= 1'b0;
		sample_ch.valid        <= 1'b0;
		sample_ch.cmd          <= CMD_COMMIT;
		sample_ch.seq_number   <= '0;
		sample_ch.sample_value <= '0;
		cfg_ch.valid           <= 1'b0;
		cfg_ch.window_length   <= '0;
		send_idle_pct = 0;
		seq_next      = '0;
		ramp_level    = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window length, then sequence errors, clear and the unused command
		send_item(CMD_PEEK,   32'd0, 32'sh1234_5678);
		send_item(CMD_COMMIT, 32'd0, 32'sh7fff_ffff);
		send_item(CMD_COMMIT, 32'd1, 32'sh8000_0000);
		send_item(CMD_PEEK,   32'd2, 32'sh8000_0000);
		send_item(CMD_COMMIT, 32'd2, 32'sh0000_0000);
		send_item(CMD_COMMIT, 32'd7, 32'shffff_ffff);
		send_item(CMD_PEEK,   32'hffff_ffff, 32'sh5555_5555);
		send_item(CMD_UNUSED, 32'd3, 32'sh0000_0001);
		send_item(CMD_CLEAR,  32'd0, 32'sh0000_0000);
		send_item(CMD_COMMIT, 32'd0, 32'shffff_ffff);

		// short window: warm-up tie, evicted minimum on peek and commit
		write_length(7'd3);
		send_item(CMD_COMMIT, 32'd0, 32'sd7);
		send_item(CMD_COMMIT, 32'd1, 32'sd7);
		send_item(CMD_COMMIT, 32'd2, 32'sd9);
		send_item(CMD_COMMIT, 32'd3, 32'sd9);
		send_item(CMD_PEEK,   32'd4, 32'sd12);
		send_item(CMD_COMMIT, 32'd4, 32'sd12);
		send_item(CMD_COMMIT, 32'd5, 32'sd3);
		send_item(CMD_COMMIT, 32'd6, 32'sd3);
		send_item(CMD_COMMIT, 32'd7, 32'sd5);
		send_item(CMD_COMMIT, 32'd8, 32'sd6);

		// length below the floor saturates to the shortest window
		write_length(7'd0);
		send_item(CMD_COMMIT, 32'd0, 32'sd4);
		send_item(CMD_COMMIT, 32'd1, 32'sd8);
		send_item(CMD_COMMIT, 32'd2, 32'sd9);

		run_segment(7'd64, 100);
		run_segment(7'd2, 150);
		run_segment(7'd127, 100);
		run_segment(7'd5, 150);
		run_segment(7'd1, 150);
		run_segment(CFG_BITS'($urandom_range(64, 2)), 150);
		run_segment(7'd100, 100);
		run_segment(CFG_BITS'($urandom_range(16, 2)), 150);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
